// ===== hw/rtl/pfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfwc_pkg
// Types, character codes and decode result for the wide format rewriter.
// ----------------------------------------------------------------------------
package pfwc_pkg;

    localparam int CHAR_BITS = 21;
    localparam int TDATA_BITS = 24;
    localparam int OUTQ_DEPTH = 3;

    typedef logic [CHAR_BITS-1:0] char_t;

    typedef enum logic [2:0] {
        MODE_TEXT   = 3'd0,
        MODE_FLAGS  = 3'd1,
        MODE_WIDTH  = 3'd2,
        MODE_PREC   = 3'd3,
        MODE_MODS   = 3'd4,
        MODE_WAFTER = 3'd5
    } mode_t;

    localparam char_t CH_NUL   = char_t'(8'h00);
    localparam char_t CH_SPACE = char_t'(8'h20);
    localparam char_t CH_HASH  = char_t'(8'h23);
    localparam char_t CH_PCT   = char_t'(8'h25);
    localparam char_t CH_QUOTE = char_t'(8'h27);
    localparam char_t CH_PLUS  = char_t'(8'h2B);
    localparam char_t CH_MINUS = char_t'(8'h2D);
    localparam char_t CH_DOT   = char_t'(8'h2E);
    localparam char_t CH_ZERO  = char_t'(8'h30);
    localparam char_t CH_NINE  = char_t'(8'h39);
    localparam char_t CH_UC_C  = char_t'(8'h43);
    localparam char_t CH_UC_I  = char_t'(8'h49);
    localparam char_t CH_UC_L  = char_t'(8'h4C);
    localparam char_t CH_UC_S  = char_t'(8'h53);
    localparam char_t CH_LC_C  = char_t'(8'h63);
    localparam char_t CH_LC_H  = char_t'(8'h68);
    localparam char_t CH_LC_L  = char_t'(8'h6C);
    localparam char_t CH_LC_S  = char_t'(8'h73);
    localparam char_t CH_LC_W  = char_t'(8'h77);

    // results produced by one request
    typedef struct packed {
        logic [1:0] count;
        char_t      c0;
        char_t      c1;
        mode_t      next_mode;
    } decode_t;

endpackage

// ===== hw/rtl/printf_format_wide_conversion_rewriter.sv =====
// ----------------------------------------------------------------------------
// printf_format_wide_conversion_rewriter
// Rewrites a wide printf format string between the two conventions for
// string and character conversions, one character per request.
// ----------------------------------------------------------------------------
// Input channel s_*: one source character per request, in s_tdata[20:0].
// Output channel m_*: rewritten characters in m_tdata[20:0]; m_tlast marks
// the final character produced by one input request. An input request gives
// zero (a held 'w' modifier), one or two output characters.
// The characters of an accepted request are registered in the result queue.
// Throughput: one input request per cycle while each gives at most one
// character and m_tready is high; the characters of a request giving two
// leave one by one through the single output port of the result queue.
// The result queue holds three characters, so a new request is taken while
// one finished character waits on a stalled receiver. With m_tready low,
// s_tready drops once the queue cannot take two more characters.
// Reset returns the parser to plain text mode and empties the queue.
// A NUL character is always passed on and returns the parser to text mode.
// ----------------------------------------------------------------------------
module printf_format_wide_conversion_rewriter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [20:0] in_char, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] out_char, [23:21] zero
    output logic        m_tlast
);

    logic              accept;
    pfwc_pkg::char_t   in_char;
    pfwc_pkg::char_t   out_char;
    pfwc_pkg::decode_t result;

    assign in_char = s_tdata[pfwc_pkg::CHAR_BITS-1:0];
    assign accept = s_tvalid && s_tready;

    pfwc_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_char (in_char),
        .result  (result)
    );

    pfwc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .result    (result),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(pfwc_pkg::TDATA_BITS - pfwc_pkg::CHAR_BITS){1'b0}}, out_char};

endmodule

// ===== hw/rtl/pfwc_decode.sv =====
// ----------------------------------------------------------------------------
// pfwc_decode
// Parser mode register and combinational rewrite of one character.
// ----------------------------------------------------------------------------
module pfwc_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pfwc_pkg::char_t     in_char,
    output pfwc_pkg::decode_t   result
);

    pfwc_pkg::mode_t mode_reg;
    pfwc_pkg::mode_t mode_next;

    logic is_flag;
    logic is_digit;
    logic is_mod;
    logic is_strconv;
    pfwc_pkg::char_t swapped;
    pfwc_pkg::decode_t first_mod;

    always_comb
    begin
        is_flag = (in_char == pfwc_pkg::CH_MINUS) || (in_char == pfwc_pkg::CH_PLUS) ||
                  (in_char == pfwc_pkg::CH_SPACE) || (in_char == pfwc_pkg::CH_HASH) ||
                  (in_char == pfwc_pkg::CH_QUOTE) || (in_char == pfwc_pkg::CH_ZERO);
        is_digit = (in_char >= pfwc_pkg::CH_ZERO) && (in_char <= pfwc_pkg::CH_NINE);
        is_mod = (in_char == pfwc_pkg::CH_LC_H) || (in_char == pfwc_pkg::CH_LC_L) ||
                 (in_char == pfwc_pkg::CH_UC_L) || (in_char == pfwc_pkg::CH_LC_W) ||
                 (in_char == pfwc_pkg::CH_UC_I);
        is_strconv = (in_char == pfwc_pkg::CH_LC_S) || (in_char == pfwc_pkg::CH_UC_S) ||
                     (in_char == pfwc_pkg::CH_LC_C) || (in_char == pfwc_pkg::CH_UC_C);

        priority if (in_char == pfwc_pkg::CH_LC_S)
            swapped = pfwc_pkg::CH_UC_S;
        else if (in_char == pfwc_pkg::CH_UC_S)
            swapped = pfwc_pkg::CH_LC_S;
        else if (in_char == pfwc_pkg::CH_LC_C)
            swapped = pfwc_pkg::CH_UC_C;
        else if (in_char == pfwc_pkg::CH_UC_C)
            swapped = pfwc_pkg::CH_LC_C;
        else
            swapped = in_char;

        // first modifier position
        first_mod.c1 = in_char;
        priority if (in_char == pfwc_pkg::CH_LC_W)
        begin
            first_mod.count = 2'd0;
            first_mod.c0 = in_char;
            first_mod.next_mode = pfwc_pkg::MODE_WAFTER;
        end
        else if (is_mod)
        begin
            first_mod.count = 2'd1;
            first_mod.c0 = in_char;
            first_mod.next_mode = pfwc_pkg::MODE_MODS;
        end
        else
        begin
            first_mod.count = 2'd1;
            first_mod.c0 = swapped;
            first_mod.next_mode = pfwc_pkg::MODE_TEXT;
        end
    end

    always_comb
    begin
        result.count = 2'd1;
        result.c0 = in_char;
        result.c1 = in_char;
        result.next_mode = pfwc_pkg::MODE_TEXT;
        unique case (mode_reg)
            pfwc_pkg::MODE_FLAGS:
            begin
                priority if (is_flag)
                    result.next_mode = pfwc_pkg::MODE_FLAGS;
                else if (is_digit)
                    result.next_mode = pfwc_pkg::MODE_WIDTH;
                else if (in_char == pfwc_pkg::CH_DOT)
                    result.next_mode = pfwc_pkg::MODE_PREC;
                else
                    result = first_mod;
            end
            pfwc_pkg::MODE_WIDTH:
            begin
                priority if (is_digit)
                    result.next_mode = pfwc_pkg::MODE_WIDTH;
                else if (in_char == pfwc_pkg::CH_DOT)
                    result.next_mode = pfwc_pkg::MODE_PREC;
                else
                    result = first_mod;
            end
            pfwc_pkg::MODE_PREC:
            begin
                if (is_digit)
                    result.next_mode = pfwc_pkg::MODE_PREC;
                else
                    result = first_mod;
            end
            pfwc_pkg::MODE_MODS:
            begin
                result.next_mode = is_mod ? pfwc_pkg::MODE_MODS : pfwc_pkg::MODE_TEXT;
            end
            pfwc_pkg::MODE_WAFTER:
            begin
                result.count = 2'd2;
                result.c0 = is_strconv ? pfwc_pkg::CH_LC_L : pfwc_pkg::CH_LC_W;
            end
            default:
            begin
                result.next_mode = (in_char == pfwc_pkg::CH_PCT) ?
                                   pfwc_pkg::MODE_FLAGS : pfwc_pkg::MODE_TEXT;
            end
        endcase
    end

    assign mode_next = accept ? result.next_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= pfwc_pkg::MODE_TEXT;
        else
            mode_reg <= mode_next;
    end

endmodule

// ===== hw/rtl/pfwc_outq.sv =====
// ----------------------------------------------------------------------------
// pfwc_outq
// Three-entry result queue; takes up to two characters per request.
// ----------------------------------------------------------------------------
module pfwc_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pfwc_pkg::decode_t   result,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output pfwc_pkg::char_t     out_char,
    output logic                out_last
);

    pfwc_pkg::char_t char_reg  [pfwc_pkg::OUTQ_DEPTH];
    logic            last_reg  [pfwc_pkg::OUTQ_DEPTH];
    pfwc_pkg::char_t char_next [pfwc_pkg::OUTQ_DEPTH];
    logic            last_next [pfwc_pkg::OUTQ_DEPTH];
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [1:0]      cnt_mid;
    logic            pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop = out_valid && out_ready;
    assign cnt_mid = cnt_reg - {1'b0, pop};
    assign space = (cnt_mid <= 2'd1);
    assign out_char = char_reg[0];
    assign out_last = last_reg[0];

    always_comb
    begin
        for (int i = 0; i < pfwc_pkg::OUTQ_DEPTH; i++)
        begin
            if (pop && (i < pfwc_pkg::OUTQ_DEPTH - 1))
            begin
                char_next[i] = char_reg[i+1];
                last_next[i] = last_reg[i+1];
            end
            else
            begin
                char_next[i] = char_reg[i];
                last_next[i] = last_reg[i];
            end
            if (push && (result.count != 2'd0) && (2'(i) == cnt_mid))
            begin
                char_next[i] = result.c0;
                last_next[i] = (result.count == 2'd1);
            end
            if (push && (result.count == 2'd2) && (2'(i) == cnt_mid + 2'd1))
            begin
                char_next[i] = result.c1;
                last_next[i] = 1'b1;
            end
        end
        cnt_next = push ? (cnt_mid + result.count) : cnt_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pfwc_pkg::OUTQ_DEPTH; i++)
        begin
            char_reg[i] <= char_next[i];
            last_reg[i] <= last_next[i];
        end
    end

endmodule
